// ===== hdl/motor_feedback_angle_accumulator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the angle accumulator blocks.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_ANGLE_ACCUMULATOR_TOP_MACROS_SVH
`define MOTOR_FEEDBACK_ANGLE_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication
`define MFAA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MFAA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mfaa_pkg.sv =====
// ----------------------------------------------------------------------------
// mfaa_pkg
// Types and constants shared by the motor feedback angle accumulator.
// ----------------------------------------------------------------------------
package mfaa_pkg;

   localparam int MOTORS_PER_BUS_DEF = 8;
   localparam logic [10:0] ID_BASE = 11'h201;
   localparam logic signed [17:0] HALF_TURN = 18'sd4095;
   localparam logic signed [17:0] FULL_TURN = 18'sd8192;
   localparam logic signed [31:0] TOTAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] TOTAL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic        bus;
      logic [2:0]  motor_index;
      logic [15:0] angle;
      logic [15:0] speed;
      logic [15:0] current;
      logic [7:0]  temp;
   } frame_type;

   typedef struct packed {
      logic [31:0] total;
      logic        tracking;
      logic [15:0] start_angle;
   } track_type;

endpackage

// ===== hdl/mfaa_in_stage.sv =====
// ----------------------------------------------------------------------------
// mfaa_in_stage
// Identifier decode, frame unpack and input register.
// ----------------------------------------------------------------------------
module mfaa_in_stage #(
   parameter int MOTORS_PER_BUS = 8,
   parameter int SLOT_W         = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_bus,
   input  logic [10:0]            req_std_id,
   input  logic [7:0]             req_byte0,
   input  logic [7:0]             req_byte1,
   input  logic [7:0]             req_byte2,
   input  logic [7:0]             req_byte3,
   input  logic [7:0]             req_byte4,
   input  logic [7:0]             req_byte5,
   input  logic [7:0]             req_byte6,
   input  logic                   advance,
   output logic                   s1_valid,
   output mfaa_pkg::frame_type    s1_frame,
   output logic [SLOT_W-1:0]      s1_slot
);
   import mfaa_pkg::*;

   logic              valid_ff, valid_in;
   frame_type         frame_ff, frame_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [10:0]       id_off;
   logic              hit;
   logic              take_ok;

   assign id_off  = req_std_id - ID_BASE;
   assign hit     = (req_std_id >= ID_BASE) && (id_off < 11'(MOTORS_PER_BUS));
   assign take_ok = !valid_ff || advance;

   assign req_stall = !take_ok;

   always_comb begin
      frame_in.bus         = req_bus;
      frame_in.motor_index = id_off[2:0];
      frame_in.angle       = {req_byte0, req_byte1};
      frame_in.speed       = {req_byte2, req_byte3};
      frame_in.current     = {req_byte4, req_byte5};
      frame_in.temp        = req_byte6;
      // second bus occupies the slots after the first
      slot_in = req_bus ? SLOT_W'(MOTORS_PER_BUS) + SLOT_W'(id_off[2:0])
                        : SLOT_W'(id_off[2:0]);
      valid_in = take_ok ? (req_valid && hit) : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_ok && req_valid) begin
         frame_ff <= frame_in;
         slot_ff  <= slot_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_frame = frame_ff;
   assign s1_slot  = slot_ff;

endmodule

// ===== hdl/mfaa_tracker.sv =====
// ----------------------------------------------------------------------------
// mfaa_tracker
// Per-slot turn tracker: state registers, wrap correction, saturating total.
// ----------------------------------------------------------------------------
`include "motor_feedback_angle_accumulator_top_macros.svh"

module mfaa_tracker #(
   parameter int SLOTS  = 16,
   parameter int SLOT_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [SLOT_W-1:0]   slot,
   input  logic [15:0]         angle,
   output mfaa_pkg::track_type res
);
   import mfaa_pkg::*;

   logic [15:0]        prev_ff  [SLOTS];
   logic signed [31:0] total_ff [SLOTS];
   logic [15:0]        start_ff [SLOTS];
   logic [SLOTS-1:0]   started_ff;

   logic [15:0]        last;
   logic signed [16:0] diff;
   logic signed [17:0] d;
   logic signed [33:0] sum;
   logic signed [31:0] sat;
   logic               same;
   logic               started_in;
   logic [15:0]        start_in;
   logic signed [31:0] total_in;

   always_comb begin
      last = prev_ff[slot];
      same = (angle == last);
      diff = $signed({1'b0, angle}) - $signed({1'b0, last});
      d    = {diff[16], diff};
      // half a turn or more apart: count it as a wrap
      if (d > HALF_TURN || d < -HALF_TURN) begin
         d = (angle < last) ? d + FULL_TURN : d - FULL_TURN;
      end
      sum = {{2{total_ff[slot][31]}}, total_ff[slot]} + {{16{d[17]}}, d};
      if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
         sat = sum[31:0];
      end else if (!sum[33]) begin
         sat = TOTAL_MAX;
      end else begin
         sat = TOTAL_MIN;
      end
      started_in = started_ff[slot] || same;
      start_in   = (same && !started_ff[slot]) ? angle : start_ff[slot];
      total_in   = started_in ? sat : total_ff[slot];
   end

   assign res.total       = total_in;
   assign res.tracking    = started_in;
   assign res.start_angle = start_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            prev_ff[i]  <= '0;
            total_ff[i] <= '0;
            start_ff[i] <= '0;
         end
      end else if (wr_en) begin
         started_ff[slot] <= started_in;
         prev_ff[slot]    <= angle;
         total_ff[slot]   <= total_in;
         start_ff[slot]   <= start_in;
      end
   end

   `MFAA_ASSERT_NEXT(a_started_sticky, clock, reset, wr_en && started_in, started_ff[$past(slot)], "tracking flag cleared")
   `MFAA_ASSERT_NEXT(a_prev_written, clock, reset, wr_en, prev_ff[$past(slot)] == $past(angle), "previous angle not stored")
   `MFAA_ASSERT_NOW(a_idle_zero, clock, reset, !res.tracking, (res.total == '0) && (res.start_angle == '0), "untracked slot holds a total")

endmodule

// ===== hdl/mfaa_out_stage.sv =====
// ----------------------------------------------------------------------------
// mfaa_out_stage
// Result register toward the response channel.
// ----------------------------------------------------------------------------
module mfaa_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mfaa_pkg::frame_type frame,
   input  mfaa_pkg::track_type track,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_out_bus,
   output logic [2:0]          rsp_motor_index,
   output logic [15:0]         rsp_angle_code,
   output logic signed [15:0]  rsp_rotor_speed,
   output logic signed [15:0]  rsp_drive_current,
   output logic [7:0]          rsp_temperature,
   output logic signed [31:0]  rsp_total_angle_out,
   output logic                rsp_tracking,
   output logic [15:0]         rsp_start_angle_out
);
   import mfaa_pkg::*;

   logic      valid_ff, valid_in;
   frame_type frame_ff;
   track_type track_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame;
         track_ff <= track;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_bus         = frame_ff.bus;
   assign rsp_motor_index     = frame_ff.motor_index;
   assign rsp_angle_code      = frame_ff.angle;
   assign rsp_rotor_speed     = $signed(frame_ff.speed);
   assign rsp_drive_current   = $signed(frame_ff.current);
   assign rsp_temperature     = frame_ff.temp;
   assign rsp_total_angle_out = $signed(track_ff.total);
   assign rsp_tracking        = track_ff.tracking;
   assign rsp_start_angle_out = track_ff.start_angle;

endmodule

// ===== hdl/motor_feedback_angle_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_angle_accumulator_top
// Unpacks motor feedback frames and keeps a saturating multi-turn angle
// per motor slot on two buses.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | bus, std_id, byte0..byte6
//  rsp_    | out       | rsp_valid/rsp_stall | motor fields, total, start
//
//  From input transfer to result: input register, then the
//  tracker update lands in the result register and the slot state together.
//  One frame per cycle sustained while rsp_stall is low; a frame for the
//  same slot in the next cycle sees the already updated state.
//  Frames with an identifier outside the motor range are taken and dropped.
//  Reset clears all slot state and both valid flags.
//  rsp_stall holds the result; req_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module motor_feedback_angle_accumulator_top #(
   parameter int MOTORS_PER_BUS = mfaa_pkg::MOTORS_PER_BUS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_bus,
   input  logic [10:0]        req_std_id,
   input  logic [7:0]         req_byte0,
   input  logic [7:0]         req_byte1,
   input  logic [7:0]         req_byte2,
   input  logic [7:0]         req_byte3,
   input  logic [7:0]         req_byte4,
   input  logic [7:0]         req_byte5,
   input  logic [7:0]         req_byte6,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_out_bus,
   output logic [2:0]         rsp_motor_index,
   output logic [15:0]        rsp_angle_code,
   output logic signed [15:0] rsp_rotor_speed,
   output logic signed [15:0] rsp_drive_current,
   output logic [7:0]         rsp_temperature,
   output logic signed [31:0] rsp_total_angle_out,
   output logic               rsp_tracking,
   output logic [15:0]        rsp_start_angle_out
);
   import mfaa_pkg::*;

   localparam int SLOTS  = 2 * MOTORS_PER_BUS;
   localparam int SLOT_W = $clog2(SLOTS);

   logic              s1_valid;
   frame_type         s1_frame;
   logic [SLOT_W-1:0] s1_slot;
   track_type         track;
   logic              advance;

   // stage 1 moves on when the result register is empty or draining
   assign advance = s1_valid && (!rsp_valid || !rsp_stall);

   mfaa_in_stage #(
      .MOTORS_PER_BUS (MOTORS_PER_BUS),
      .SLOT_W         (SLOT_W)
   ) u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_bus    (req_bus),
      .req_std_id (req_std_id),
      .req_byte0  (req_byte0),
      .req_byte1  (req_byte1),
      .req_byte2  (req_byte2),
      .req_byte3  (req_byte3),
      .req_byte4  (req_byte4),
      .req_byte5  (req_byte5),
      .req_byte6  (req_byte6),
      .advance    (advance),
      .s1_valid   (s1_valid),
      .s1_frame   (s1_frame),
      .s1_slot    (s1_slot)
   );

   mfaa_tracker #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .wr_en (advance),
      .slot  (s1_slot),
      .angle (s1_frame.angle),
      .res   (track)
   );

   mfaa_out_stage u_out (
      .clock               (clock),
      .reset               (reset),
      .load                (advance),
      .frame               (s1_frame),
      .track               (track),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_bus         (rsp_out_bus),
      .rsp_motor_index     (rsp_motor_index),
      .rsp_angle_code      (rsp_angle_code),
      .rsp_rotor_speed     (rsp_rotor_speed),
      .rsp_drive_current   (rsp_drive_current),
      .rsp_temperature     (rsp_temperature),
      .rsp_total_angle_out (rsp_total_angle_out),
      .rsp_tracking        (rsp_tracking),
      .rsp_start_angle_out (rsp_start_angle_out)
   );

endmodule
